### design/assert_macros.svh
// assertion helpers included by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the cycle after the condition
`define ASSERT_NEXT(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

### design/plhs_pkg.sv
// ----------------------------------------------------------------------------
// plhs_pkg
// shared types, constants and bucket math for the latency histogram monitor
// ----------------------------------------------------------------------------
package plhs_pkg;

    localparam int MAX_SCOPES      = 64;
    localparam int SLOT_W          = 6;
    localparam int SUB_BUCKET_BITS = 5;
    localparam int SUB_COUNT       = 1 << SUB_BUCKET_BITS;
    localparam int BUCKET_COUNT    = 1536;
    localparam int BUCKET_W        = $clog2(BUCKET_COUNT);
    localparam int PERCENT_MAX     = 100;
    localparam int PCT_W           = 7;
    localparam int OPC_W           = 3;
    localparam int AMOUNT_W        = 40;
    localparam int NANO_W          = 48;
    localparam int OCT_W           = $clog2(NANO_W);
    localparam int CALL_W          = 32;
    localparam int SUM_W           = 64;
    localparam int CNT_W           = 32;
    localparam int HIT_W           = 32;
    localparam int BKT_DEPTH       = MAX_SCOPES * BUCKET_COUNT;
    localparam int BKT_AW          = $clog2(BKT_DEPTH);
    localparam int TGT_W           = CNT_W + PCT_W;
    localparam int CUM_W           = TGT_W + 1;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

    typedef enum logic [OPC_W-1:0] {
        OP_ADD_SAMPLE = 3'd0,
        OP_ADD_COUNT  = 3'd1,
        OP_END_FRAME  = 3'd2,
        OP_QUERY      = 3'd3,
        OP_CLEAR      = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        CMD_SAMPLE,
        CMD_COUNT,
        CMD_END_FRAME,
        CMD_QUERY,
        CMD_CLEAR
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC,
        ST_EF_RD,
        ST_EF_CALC,
        ST_EF_BRD,
        ST_EF_BWR,
        ST_Q_ST,
        ST_Q_BRD,
        ST_Q_BCHK,
        ST_Q_OUT
    } back_state_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [SLOT_W-1:0]   slot;
        logic [AMOUNT_W-1:0] amount;
        logic [PCT_W-1:0]    pct;
    } q_entry_t;

    typedef struct packed {
        logic init_busy;
        logic idle;
    } back_status_t;

    typedef struct packed {
        logic [NANO_W-1:0] tacc;
        logic [CALL_W-1:0] cacc;
    } frame_entry_t;

    typedef struct packed {
        logic [SUM_W-1:0]  tsum;
        logic [SUM_W-1:0]  csum;
        logic [NANO_W-1:0] tmin;
        logic [NANO_W-1:0] tmax;
        logic [CNT_W-1:0]  fwc;
    } stats_entry_t;

    // position of the leading one
    function automatic logic [OCT_W-1:0] lead_pos(input logic [NANO_W-1:0] v);
        logic [OCT_W-1:0] p;
        p = '0;
        for (int i = 0; i < NANO_W; i++) begin
            if (v[i]) begin
                p = OCT_W'(i);
            end
        end
        return p;
    endfunction

    // log-linear bucket of a value whose octave is already known
    function automatic logic [BUCKET_W-1:0] bucket_of(input logic [NANO_W-1:0] v,
                                                      input logic [OCT_W-1:0] oct);
        logic [OCT_W-1:0]  sh;
        logic [NANO_W-1:0] shifted;
        logic [BUCKET_W:0] idx;
        if (v < NANO_W'(SUB_COUNT)) begin
            idx = (BUCKET_W+1)'(v[SUB_BUCKET_BITS-1:0]);
        end
        else begin
            sh      = oct - OCT_W'(SUB_BUCKET_BITS);
            shifted = v >> sh;
            idx     = ((BUCKET_W+1)'(oct) << SUB_BUCKET_BITS)
                      + (BUCKET_W+1)'(shifted[SUB_BUCKET_BITS-1:0]);
        end
        if (idx >= (BUCKET_W+1)'(BUCKET_COUNT)) begin
            idx = (BUCKET_W+1)'(BUCKET_COUNT - 1);
        end
        return idx[BUCKET_W-1:0];
    endfunction

    // lower bound of a bucket
    function automatic logic [NANO_W-1:0] bucket_low(input logic [BUCKET_W-1:0] b);
        logic [BUCKET_W-SUB_BUCKET_BITS-1:0] oct;
        logic [SUB_BUCKET_BITS-1:0]          man;
        logic [NANO_W-1:0]                   r;
        oct = b[BUCKET_W-1:SUB_BUCKET_BITS];
        man = b[SUB_BUCKET_BITS-1:0];
        if (b < BUCKET_W'(SUB_COUNT)) begin
            r = NANO_W'(b);
        end
        else if (int'(oct) + 1 > NANO_W) begin
            r = '1;
        end
        else begin
            r = NANO_W'({1'b1, man}) << (NANO_W'(oct) - NANO_W'(SUB_BUCKET_BITS));
        end
        return r;
    endfunction

endpackage

### design/per_slot_latency_histogram_stats.sv
// ----------------------------------------------------------------------------
// per_slot_latency_histogram_stats
// per-slot frame timing monitor with log-linear histograms and percentiles
// ----------------------------------------------------------------------------
// add-sample and add-count: a read and then a write in the back sequencer
// end-frame: a pop, then a read and an update per slot, plus a bucket read and write per slot with calls, over 64 slots
// query: a stats read, then a bucket read and check per histogram bucket scanned, then the result
// clear: a pop, then one bucket memory word per cycle over the whole bucket memory
// reset: async, active low; a clearing pass over all 98304 bucket memory words follows with input stalled
// ----------------------------------------------------------------------------
module per_slot_latency_histogram_stats (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration: enable bit
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data,
    // input items
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [plhs_pkg::OPC_W-1:0]    opcode,
    input  logic [plhs_pkg::SLOT_W-1:0]   slot,
    input  logic [plhs_pkg::AMOUNT_W-1:0] amount,
    input  logic [plhs_pkg::PCT_W-1:0]    percent,
    // query results
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [plhs_pkg::NANO_W-1:0]   percentile_nanos,
    output logic [plhs_pkg::NANO_W-1:0]   min_nanos,
    output logic [plhs_pkg::NANO_W-1:0]   max_nanos,
    output logic [plhs_pkg::SUM_W-1:0]    total_nanos,
    output logic [plhs_pkg::SUM_W-1:0]    total_calls,
    output logic [plhs_pkg::CNT_W-1:0]    sampled_frames,
    output logic [plhs_pkg::CNT_W-1:0]    frames_ended
);
    import plhs_pkg::*;

    `include "assert_macros.svh"

    // front to queue
    logic         q_push;
    q_entry_t     q_wdata;
    logic         q_full;
    // queue to back
    logic         q_pop;
    q_entry_t     q_head;
    logic         q_empty;
    // back status seen by the front
    back_status_t status;

    // front: takes each transfer, filters no-op items, clamps the percentile
    plhs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .slot      (slot),
        .amount    (amount),
        .percent   (percent),
        .q_push    (q_push),
        .q_wdata   (q_wdata),
        .q_full    (q_full),
        .status    (status)
    );

    // two-entry queue decouples acceptance from execution
    plhs_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_head),
        .empty (q_empty)
    );

    // back: sequencer over slot, statistics and bucket memories, result register
    plhs_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .status           (status),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .percentile_nanos (percentile_nanos),
        .min_nanos        (min_nanos),
        .max_nanos        (max_nanos),
        .total_nanos      (total_nanos),
        .total_calls      (total_calls),
        .sampled_frames   (sampled_frames),
        .frames_ended     (frames_ended)
    );

    // no transfer is taken while the clearing pass after reset runs
    `ASSERT_ALWAYS(a_init_stall, !status.init_busy || in_stall, "input taken during init clear")
    // queue never written when full
    `ASSERT_ALWAYS(a_q_no_overflow, !(q_push && q_full), "command queue overflow")
    // back never pops an empty queue
    `ASSERT_ALWAYS(a_q_no_underflow, !(q_pop && q_empty), "command queue underflow")
    // a pop moves the back out of idle
    `ASSERT_NEXT(a_pop_leaves_idle, q_pop, !status.idle, "back stayed idle after pop")

endmodule

### design/plhs_fifo.sv
// ----------------------------------------------------------------------------
// plhs_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module plhs_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  plhs_pkg::q_entry_t wdata,
    output logic               full,
    input  logic               pop,
    output plhs_pkg::q_entry_t rdata,
    output logic               empty
);
    import plhs_pkg::*;

    q_entry_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### design/plhs_front.sv
// ----------------------------------------------------------------------------
// plhs_front
// input acceptance, enable register and command classification
// ----------------------------------------------------------------------------
module plhs_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [plhs_pkg::OPC_W-1:0]    opcode,
    input  logic [plhs_pkg::SLOT_W-1:0]   slot,
    input  logic [plhs_pkg::AMOUNT_W-1:0] amount,
    input  logic [plhs_pkg::PCT_W-1:0]    percent,
    output logic                          q_push,
    output plhs_pkg::q_entry_t            q_wdata,
    input  logic                          q_full,
    input  plhs_pkg::back_status_t        status
);
    import plhs_pkg::*;

    logic enable_reg;
    logic keep;
    logic accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full || status.init_busy;
    assign accept    = in_valid && !in_stall;
    assign q_push    = accept && keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            enable_reg <= cfg_data;
        end
    end

    // drop items that have no effect
    always_comb
    begin
        keep           = 1'b0;
        q_wdata.cmd    = CMD_SAMPLE;
        q_wdata.slot   = slot;
        q_wdata.amount = amount;
        q_wdata.pct    = (percent > PCT_W'(PERCENT_MAX)) ? PCT_W'(PERCENT_MAX) : percent;
        case (opcode)
            OP_ADD_SAMPLE:
            begin
                keep        = 1'b1;
                q_wdata.cmd = CMD_SAMPLE;
            end
            OP_ADD_COUNT:
            begin
                keep        = enable_reg;
                q_wdata.cmd = CMD_COUNT;
            end
            OP_END_FRAME:
            begin
                keep        = enable_reg;
                q_wdata.cmd = CMD_END_FRAME;
            end
            OP_QUERY:
            begin
                keep        = 1'b1;
                q_wdata.cmd = CMD_QUERY;
            end
            OP_CLEAR:
            begin
                keep        = 1'b1;
                q_wdata.cmd = CMD_CLEAR;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

### design/plhs_back.sv
// ----------------------------------------------------------------------------
// plhs_back
// command sequencer over the slot, statistics and bucket memories
// ----------------------------------------------------------------------------
module plhs_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  plhs_pkg::q_entry_t          q_head,
    output logic                        q_pop,
    output plhs_pkg::back_status_t      status,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [plhs_pkg::NANO_W-1:0] percentile_nanos,
    output logic [plhs_pkg::NANO_W-1:0] min_nanos,
    output logic [plhs_pkg::NANO_W-1:0] max_nanos,
    output logic [plhs_pkg::SUM_W-1:0]  total_nanos,
    output logic [plhs_pkg::SUM_W-1:0]  total_calls,
    output logic [plhs_pkg::CNT_W-1:0]  sampled_frames,
    output logic [plhs_pkg::CNT_W-1:0]  frames_ended
);
    import plhs_pkg::*;

    frame_entry_t frame_mem [MAX_SCOPES];
    stats_entry_t stats_mem [MAX_SCOPES];
    logic [HIT_W-1:0] bkt_mem [BKT_DEPTH];

    back_state_t       state_reg, state_next;
    logic              init_busy_reg, init_busy_next;
    logic [BKT_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [SLOT_W-1:0] slot_cnt_reg, slot_cnt_next;
    logic [CNT_W-1:0]  frame_cnt_reg, frame_cnt_next;
    logic              out_valid_reg, out_valid_next;

    q_entry_t          cur_reg, cur_next;
    frame_entry_t      frame_rd_reg;
    stats_entry_t      stats_rd_reg;
    logic [HIT_W-1:0]  bkt_rd_reg;
    logic [NANO_W-1:0] t_reg, t_next;
    logic [OCT_W-1:0]  oct_reg, oct_next;
    logic [BKT_AW-1:0] bkt_addr_reg, bkt_addr_next;
    logic [BUCKET_W-1:0] bidx_reg, bidx_next;
    logic [CUM_W-1:0]  cum_reg, cum_next;
    logic [TGT_W-1:0]  target_reg, target_next;
    logic [NANO_W-1:0] pctl_reg, pctl_next;
    stats_entry_t      qst_reg, qst_next;

    logic [NANO_W-1:0] res_pctl_reg, res_pctl_next;
    stats_entry_t      res_st_reg, res_st_next;
    logic [CNT_W-1:0]  res_fe_reg, res_fe_next;

    logic              frame_we, stats_we, bkt_we;
    logic [SLOT_W-1:0] frame_waddr, frame_raddr, stats_waddr, stats_raddr;
    frame_entry_t      frame_wdata;
    stats_entry_t      stats_wdata;
    logic [BKT_AW-1:0] bkt_waddr, bkt_raddr;
    logic [HIT_W-1:0]  bkt_wdata;

    logic [NANO_W:0]   tacc_sum;
    logic [AMOUNT_W:0] cacc_sum;
    logic [CUM_W-1:0]  cum_sum;
    logic [BKT_AW-1:0] walk_addr;
    logic              last_slot;

    assign status.init_busy = init_busy_reg;
    assign status.idle      = (state_reg == ST_IDLE);

    assign out_valid        = out_valid_reg;
    assign percentile_nanos = res_pctl_reg;
    assign min_nanos        = res_st_reg.tmin;
    assign max_nanos        = res_st_reg.tmax;
    assign total_nanos      = res_st_reg.tsum;
    assign total_calls      = res_st_reg.csum;
    assign sampled_frames   = res_st_reg.fwc;
    assign frames_ended     = res_fe_reg;

    assign tacc_sum  = {1'b0, frame_rd_reg.tacc} + (NANO_W+1)'(cur_reg.amount);
    assign cacc_sum  = (AMOUNT_W+1)'(frame_rd_reg.cacc) + {1'b0, cur_reg.amount};
    assign cum_sum   = cum_reg + CUM_W'(bkt_rd_reg) * CUM_W'(PERCENT_MAX);
    assign last_slot = (slot_cnt_reg == SLOT_W'(MAX_SCOPES - 1));

    // memories
    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_mem[frame_waddr] <= frame_wdata;
        end
        frame_rd_reg <= frame_mem[frame_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stats_we)
        begin
            stats_mem[stats_waddr] <= stats_wdata;
        end
        stats_rd_reg <= stats_mem[stats_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (bkt_we)
        begin
            bkt_mem[bkt_waddr] <= bkt_wdata;
        end
        bkt_rd_reg <= bkt_mem[bkt_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            init_busy_reg <= 1'b1;
            clr_cnt_reg   <= '0;
            slot_cnt_reg  <= '0;
            frame_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_busy_reg <= init_busy_next;
            clr_cnt_reg   <= clr_cnt_next;
            slot_cnt_reg  <= slot_cnt_next;
            frame_cnt_reg <= frame_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        t_reg        <= t_next;
        oct_reg      <= oct_next;
        bkt_addr_reg <= bkt_addr_next;
        bidx_reg     <= bidx_next;
        cum_reg      <= cum_next;
        target_reg   <= target_next;
        pctl_reg     <= pctl_next;
        qst_reg      <= qst_next;
        res_pctl_reg <= res_pctl_next;
        res_st_reg   <= res_st_next;
        res_fe_reg   <= res_fe_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        init_busy_next = init_busy_reg;
        clr_cnt_next   = clr_cnt_reg;
        slot_cnt_next  = slot_cnt_reg;
        frame_cnt_next = frame_cnt_reg;
        out_valid_next = out_valid_reg;
        cur_next       = cur_reg;
        t_next         = t_reg;
        oct_next       = oct_reg;
        bkt_addr_next  = bkt_addr_reg;
        bidx_next      = bidx_reg;
        cum_next       = cum_reg;
        target_next    = target_reg;
        pctl_next      = pctl_reg;
        qst_next       = qst_reg;
        res_pctl_next  = res_pctl_reg;
        res_st_next    = res_st_reg;
        res_fe_next    = res_fe_reg;
        q_pop          = 1'b0;
        frame_we       = 1'b0;
        frame_waddr    = cur_reg.slot;
        frame_wdata    = '0;
        frame_raddr    = cur_reg.slot;
        stats_we       = 1'b0;
        stats_waddr    = cur_reg.slot;
        stats_wdata    = stats_rd_reg;
        stats_raddr    = cur_reg.slot;
        bkt_we         = 1'b0;
        bkt_waddr      = bkt_addr_reg;
        bkt_wdata      = '0;
        bkt_raddr      = bkt_addr_reg;
        walk_addr      = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                bkt_we         = 1'b1;
                bkt_waddr      = clr_cnt_reg;
                frame_waddr    = clr_cnt_reg[SLOT_W-1:0];
                stats_waddr    = clr_cnt_reg[SLOT_W-1:0];
                stats_wdata    = '0;
                frame_we       = (clr_cnt_reg < BKT_AW'(MAX_SCOPES));
                stats_we       = (clr_cnt_reg < BKT_AW'(MAX_SCOPES));
                frame_cnt_next = '0;
                if (clr_cnt_reg == BKT_AW'(BKT_DEPTH - 1))
                begin
                    init_busy_next = 1'b0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                frame_raddr = q_head.slot;
                stats_raddr = q_head.slot;
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    case (q_head.cmd)
                        CMD_SAMPLE, CMD_COUNT:
                        begin
                            state_next = ST_ACC;
                        end
                        CMD_END_FRAME:
                        begin
                            slot_cnt_next = '0;
                            state_next    = ST_EF_RD;
                        end
                        CMD_QUERY:
                        begin
                            state_next = ST_Q_ST;
                        end
                        CMD_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ACC:
            begin
                frame_we    = 1'b1;
                frame_wdata = frame_rd_reg;
                if (cur_reg.cmd == CMD_SAMPLE)
                begin
                    frame_wdata.tacc = tacc_sum[NANO_W] ? '1 : tacc_sum[NANO_W-1:0];
                    if (frame_rd_reg.cacc != '1)
                    begin
                        frame_wdata.cacc = frame_rd_reg.cacc + 1'b1;
                    end
                end
                else
                begin
                    frame_wdata.cacc = (cacc_sum[AMOUNT_W:CALL_W] != '0) ? '1
                                       : cacc_sum[CALL_W-1:0];
                end
                state_next = ST_IDLE;
            end
            ST_EF_RD:
            begin
                frame_raddr = slot_cnt_reg;
                stats_raddr = slot_cnt_reg;
                state_next  = ST_EF_CALC;
            end
            ST_EF_CALC:
            begin
                frame_we    = 1'b1;
                frame_waddr = slot_cnt_reg;
                frame_wdata = '0;
                if (frame_rd_reg.cacc != '0)
                begin
                    stats_we         = 1'b1;
                    stats_waddr      = slot_cnt_reg;
                    stats_wdata.tsum = stats_rd_reg.tsum + SUM_W'(frame_rd_reg.tacc);
                    stats_wdata.csum = stats_rd_reg.csum + SUM_W'(frame_rd_reg.cacc);
                    if (stats_rd_reg.fwc == '0 || frame_rd_reg.tacc < stats_rd_reg.tmin)
                    begin
                        stats_wdata.tmin = frame_rd_reg.tacc;
                    end
                    if (frame_rd_reg.tacc > stats_rd_reg.tmax)
                    begin
                        stats_wdata.tmax = frame_rd_reg.tacc;
                    end
                    if (stats_rd_reg.fwc != '1)
                    begin
                        stats_wdata.fwc = stats_rd_reg.fwc + 1'b1;
                    end
                    t_next     = frame_rd_reg.tacc;
                    oct_next   = lead_pos(frame_rd_reg.tacc);
                    state_next = ST_EF_BRD;
                end
                else if (last_slot)
                begin
                    frame_cnt_next = frame_cnt_reg + 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    slot_cnt_next = slot_cnt_reg + 1'b1;
                    state_next    = ST_EF_RD;
                end
            end
            ST_EF_BRD:
            begin
                walk_addr     = BKT_AW'(slot_cnt_reg) * BKT_AW'(BUCKET_COUNT)
                                + BKT_AW'(bucket_of(t_reg, oct_reg));
                bkt_raddr     = walk_addr;
                bkt_addr_next = walk_addr;
                state_next    = ST_EF_BWR;
            end
            ST_EF_BWR:
            begin
                bkt_we    = 1'b1;
                bkt_wdata = (bkt_rd_reg == '1) ? bkt_rd_reg : bkt_rd_reg + 1'b1;
                if (last_slot)
                begin
                    frame_cnt_next = frame_cnt_reg + 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    slot_cnt_next = slot_cnt_reg + 1'b1;
                    state_next    = ST_EF_RD;
                end
            end
            ST_Q_ST:
            begin
                qst_next    = stats_rd_reg;
                target_next = TGT_W'(stats_rd_reg.fwc) * TGT_W'(cur_reg.pct);
                cum_next    = '0;
                bidx_next   = '0;
                if (cur_reg.pct == '0 || stats_rd_reg.fwc == '0)
                begin
                    pctl_next  = '0;
                    state_next = ST_Q_OUT;
                end
                else
                begin
                    state_next = ST_Q_BRD;
                end
            end
            ST_Q_BRD:
            begin
                bkt_raddr  = BKT_AW'(cur_reg.slot) * BKT_AW'(BUCKET_COUNT) + BKT_AW'(bidx_reg);
                state_next = ST_Q_BCHK;
            end
            ST_Q_BCHK:
            begin
                cum_next = cum_sum;
                if (cum_sum >= CUM_W'(target_reg))
                begin
                    pctl_next  = bucket_low(bidx_reg);
                    state_next = ST_Q_OUT;
                end
                else if (bidx_reg == BUCKET_W'(BUCKET_COUNT - 1))
                begin
                    pctl_next  = qst_reg.tmax;
                    state_next = ST_Q_OUT;
                end
                else
                begin
                    bidx_next  = bidx_reg + 1'b1;
                    state_next = ST_Q_BRD;
                end
            end
            ST_Q_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    res_pctl_next  = pctl_reg;
                    res_st_next    = qst_reg;
                    res_fe_next    = frame_cnt_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### bench/per_slot_latency_histogram_stats_test.sv
// ----------------------------------------------------------------------------
// per_slot_latency_histogram_stats_test
// drives sample, count, end-frame, query and clear transfers into the monitor,
// predicts every slot's frame sums, running stats and histogram on the side,
// and checks each query answer field by field against the predicted one
// ----------------------------------------------------------------------------
module per_slot_latency_histogram_stats_test;
    timeunit 1ns;
    timeprecision 1ps;

    import plhs_pkg::*;

    // opcodes the block ignores
    localparam logic [OPC_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OPC_W-1:0] OP_SPARE_LAST  = 3'd7;

    localparam logic [NANO_W-1:0]   NANO_SAT   = '1;
    localparam logic [CALL_W-1:0]   CALL_SAT   = '1;
    localparam logic [HIT_W-1:0]    HIT_SAT    = '1;
    localparam logic [CNT_W-1:0]    FRAME_SAT  = '1;
    localparam logic [AMOUNT_W-1:0] AMOUNT_TOP = '1;

    // settle wait after each drain and overall simulation limit, in cycles
    localparam int SETTLE_CYCLES = 2 * 2 * BUCKET_COUNT + 300;
    localparam longint CYCLE_LIMIT = 64'd12_000_000;

    typedef struct packed {
        logic [OPC_W-1:0]    op;
        logic [SLOT_W-1:0]   slot;
        logic [AMOUNT_W-1:0] amount;
        logic [PCT_W-1:0]    pct;
    } monitor_cmd_t;

    typedef struct packed {
        logic [NANO_W-1:0] pctl;
        logic [NANO_W-1:0] tmin;
        logic [NANO_W-1:0] tmax;
        logic [SUM_W-1:0]  tsum;
        logic [SUM_W-1:0]  csum;
        logic [CNT_W-1:0]  fwc;
        logic [CNT_W-1:0]  frames;
    } slot_report_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_data;
    logic in_valid;
    logic in_stall;
    logic [OPC_W-1:0]    opcode;
    logic [SLOT_W-1:0]   slot;
    logic [AMOUNT_W-1:0] amount;
    logic [PCT_W-1:0]    percent;
    logic out_valid;
    logic out_stall;
    logic [NANO_W-1:0] percentile_nanos;
    logic [NANO_W-1:0] min_nanos;
    logic [NANO_W-1:0] max_nanos;
    logic [SUM_W-1:0]  total_nanos;
    logic [SUM_W-1:0]  total_calls;
    logic [CNT_W-1:0]  sampled_frames;
    logic [CNT_W-1:0]  frames_ended;

    per_slot_latency_histogram_stats i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .slot             (slot),
        .amount           (amount),
        .percent          (percent),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .percentile_nanos (percentile_nanos),
        .min_nanos        (min_nanos),
        .max_nanos        (max_nanos),
        .total_nanos      (total_nanos),
        .total_calls      (total_calls),
        .sampled_frames   (sampled_frames),
        .frames_ended     (frames_ended)
    );

    // ------------------------------------------------------------------------
    // shadow copy of the monitor state
    // ------------------------------------------------------------------------
    logic              shadow_enable;
    logic [NANO_W-1:0] acc_nanos [MAX_SCOPES];
    logic [CALL_W-1:0] acc_calls [MAX_SCOPES];
    logic [SUM_W-1:0]  run_nanos [MAX_SCOPES];
    logic [SUM_W-1:0]  run_calls [MAX_SCOPES];
    logic [NANO_W-1:0] low_nanos [MAX_SCOPES];
    logic [NANO_W-1:0] high_nanos[MAX_SCOPES];
    logic [CNT_W-1:0]  busy_frames[MAX_SCOPES];
    logic [HIT_W-1:0]  hist_hits [MAX_SCOPES][BUCKET_COUNT];
    logic [CNT_W-1:0]  frame_count;

    monitor_cmd_t pending_cmds[$];
    slot_report_t awaited_reports[$];

    int  error_count;
    bit  quiet_mode;       // stretches with no idling on either side
    bit  long_hold;        // receiver holds off for a long stretch
    bit  start_hold;
    int  send_gap;
    int  recv_gap;
    int  transfer_count;
    longint cycle_count;

    function automatic void wipe_shadow();
        for (int s = 0; s < MAX_SCOPES; s++) begin
            acc_nanos[s]   = '0;
            acc_calls[s]   = '0;
            run_nanos[s]   = '0;
            run_calls[s]   = '0;
            low_nanos[s]   = '0;
            high_nanos[s]  = '0;
            busy_frames[s] = '0;
            for (int b = 0; b < BUCKET_COUNT; b++) begin
                hist_hits[s][b] = '0;
            end
        end
        frame_count = '0;
    endfunction

    // log-linear bucket: exact below one octave, else octave and top sub-bits
    function automatic int hist_slot_of(logic [NANO_W-1:0] v);
        int oct;
        int idx;
        if (v < SUB_COUNT) begin
            idx = int'(v);
        end
        else begin
            oct = 0;
            for (int i = 0; i < NANO_W; i++) begin
                if (v[i]) oct = i;
            end
            idx = oct * SUB_COUNT + int'((v >> (oct - SUB_BUCKET_BITS)) & (SUB_COUNT - 1));
        end
        if (idx >= BUCKET_COUNT) idx = BUCKET_COUNT - 1;
        return idx;
    endfunction

    function automatic logic [NANO_W-1:0] hist_floor(int b);
        int oct;
        logic [63:0] base;
        if (b < SUB_COUNT) return NANO_W'(b);
        oct = b / SUB_COUNT;
        if (oct + 1 > NANO_W) return NANO_SAT;
        base = 64'(SUB_COUNT + (b % SUB_COUNT));
        return NANO_W'(base << (oct - SUB_BUCKET_BITS));
    endfunction

    // fold every slot that saw calls into its running stats
    function automatic void close_frame();
        logic [NANO_W-1:0] t;
        int b;
        for (int s = 0; s < MAX_SCOPES; s++) begin
            t = acc_nanos[s];
            if (acc_calls[s] != 0) begin
                run_nanos[s] = run_nanos[s] + SUM_W'(t);
                run_calls[s] = run_calls[s] + SUM_W'(acc_calls[s]);
                if (busy_frames[s] == 0 || t < low_nanos[s]) low_nanos[s] = t;
                if (t > high_nanos[s]) high_nanos[s] = t;
                b = hist_slot_of(t);
                if (hist_hits[s][b] != HIT_SAT) hist_hits[s][b]++;
                if (busy_frames[s] != FRAME_SAT) busy_frames[s]++;
            end
            acc_nanos[s] = '0;
            acc_calls[s] = '0;
        end
        frame_count = frame_count + 1;
    endfunction

    // ceil-rank percentile as the lower bound of the bucket that holds it
    function automatic logic [NANO_W-1:0] slot_percentile(int s, int pct);
        logic [63:0] rank;
        logic [63:0] cum;
        if (pct == 0 || busy_frames[s] == 0) return '0;
        if (pct > PERCENT_MAX) pct = PERCENT_MAX;
        rank = (64'(busy_frames[s]) * 64'(pct) + 64'(PERCENT_MAX - 1)) / 64'(PERCENT_MAX);
        cum = '0;
        for (int b = 0; b < BUCKET_COUNT; b++) begin
            cum = cum + 64'(hist_hits[s][b]);
            if (cum >= rank) return hist_floor(b);
        end
        return high_nanos[s];
    endfunction

    // one accepted transfer into the shadow state
    function automatic void track_command(monitor_cmd_t c);
        logic [63:0]  sum;
        slot_report_t r;
        int s;
        s = int'(c.slot);
        case (c.op)
            OP_ADD_SAMPLE: begin
                sum = 64'(acc_nanos[s]) + 64'(c.amount);
                acc_nanos[s] = (sum > 64'(NANO_SAT)) ? NANO_SAT : NANO_W'(sum);
                if (acc_calls[s] != CALL_SAT) acc_calls[s]++;
            end
            OP_ADD_COUNT: begin
                if (shadow_enable) begin
                    sum = 64'(acc_calls[s]) + 64'(c.amount);
                    acc_calls[s] = (sum > 64'(CALL_SAT)) ? CALL_SAT : CALL_W'(sum);
                end
            end
            OP_END_FRAME: begin
                if (shadow_enable) close_frame();
            end
            OP_QUERY: begin
                r.pctl   = slot_percentile(s, int'(c.pct));
                r.tmin   = low_nanos[s];
                r.tmax   = high_nanos[s];
                r.tsum   = run_nanos[s];
                r.csum   = run_calls[s];
                r.fwc    = busy_frames[s];
                r.frames = frame_count;
                awaited_reports.push_back(r);
            end
            OP_CLEAR: wipe_shadow();
            default: ;
        endcase
    endfunction

    function automatic int draw_gap();
        return quiet_mode ? 0 : int'($urandom_range(0, 18));
    endfunction

    // ------------------------------------------------------------------------
    // clock, reset, cycle limit
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
    end

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("per_slot_latency_histogram_stats_test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // input driver: pops pending commands, waits a drawn gap after each transfer
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        monitor_cmd_t c;
        if (!rst_n) begin
            in_valid <= 1'b0;
            opcode   <= '0;
            slot     <= '0;
            amount   <= '0;
            percent  <= '0;
            send_gap = 0;
        end
        else begin
            if (in_valid && !in_stall) begin
                c.op     = opcode;
                c.slot   = slot;
                c.amount = amount;
                c.pct    = percent;
                track_command(c);
                send_gap = draw_gap();
                transfer_count++;
                // flip between idling and back-to-back stretches
                if (transfer_count % 97 == 0) quiet_mode = ~quiet_mode;
            end
            // payload only moves when nothing is waiting on the stall
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0) begin
                    c = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    opcode   <= c.op;
                    slot     <= c.slot;
                    amount   <= c.amount;
                    percent  <= c.pct;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor and receiver stall
    // ------------------------------------------------------------------------
    task automatic compare_field(string name, logic [63:0] expv, logic [63:0] actv);
        if (expv !== actv) begin
            $display("%0t mismatch %s expected %h actual %h", $realtime, name, expv, actv);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        slot_report_t r;
        if (!rst_n) begin
            out_stall <= 1'b1;
            recv_gap = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (awaited_reports.size() == 0) begin
                    $display("%0t unexpected query result, expected none actual %h",
                             $realtime, percentile_nanos);
                    error_count++;
                end
                else begin
                    r = awaited_reports.pop_front();
                    compare_field("percentile_nanos", 64'(r.pctl), 64'(percentile_nanos));
                    compare_field("min_nanos", 64'(r.tmin), 64'(min_nanos));
                    compare_field("max_nanos", 64'(r.tmax), 64'(max_nanos));
                    compare_field("total_nanos", r.tsum, total_nanos);
                    compare_field("total_calls", r.csum, total_calls);
                    compare_field("sampled_frames", 64'(r.fwc), 64'(sampled_frames));
                    compare_field("frames_ended", 64'(r.frames), 64'(frames_ended));
                end
                recv_gap = draw_gap();
            end
            else if (recv_gap > 0) begin
                recv_gap--;
            end
            out_stall <= long_hold || (recv_gap > 0);
        end
    end

    // long receiver hold-off so the block fills and stalls its input
    initial begin
        long_hold = 1'b0;
        wait (start_hold);
        repeat (40) @(posedge clk);
        long_hold = 1'b1;
        repeat (5000) @(posedge clk);
        long_hold = 1'b0;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    function automatic monitor_cmd_t make_cmd(logic [OPC_W-1:0] op, int s,
                                              logic [AMOUNT_W-1:0] a, int p);
        monitor_cmd_t c;
        c.op     = op;
        c.slot   = SLOT_W'(s);
        c.amount = a;
        c.pct    = PCT_W'(p);
        return c;
    endfunction

    // durations spread over every octave the field reaches
    function automatic logic [AMOUNT_W-1:0] draw_duration();
        logic [63:0] raw;
        int w;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return AMOUNT_W'($urandom_range(0, 40));
            1: return AMOUNT_W'(raw);
            default: begin
                w = $urandom_range(1, AMOUNT_W);
                return AMOUNT_W'(raw & ((64'd1 << w) - 1));
            end
        endcase
    endfunction

    function automatic logic [AMOUNT_W-1:0] draw_calls();
        if ($urandom_range(0, 15) == 0) return AMOUNT_W'({$urandom, $urandom});
        return AMOUNT_W'($urandom_range(0, 5));
    endfunction

    function automatic int draw_pct();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 127);
            1: return PERCENT_MAX;
            default: return $urandom_range(1, PERCENT_MAX);
        endcase
    endfunction

    // well-formed frames over a few hot slots, with some noise and an optional clear mixed in
    task automatic queue_random_phase(int n_cmds, bit with_clear);
        int hot[4];
        int made;
        int k;
        int clear_at;
        int op_draw;
        made = 0;
        clear_at = with_clear ? $urandom_range(n_cmds / 4, n_cmds / 2) : -1;
        for (int i = 0; i < 4; i++) hot[i] = $urandom_range(0, MAX_SCOPES - 1);
        while (made < n_cmds) begin
            if (clear_at >= 0 && made >= clear_at) begin
                pending_cmds.push_back(make_cmd(OP_CLEAR, $urandom_range(0, 63),
                                                draw_duration(), $urandom_range(0, 127)));
                made++;
                clear_at = -1;
            end
            else if ($urandom_range(0, 9) == 0) begin
                // noise: any opcode but clear, spares included, any slot
                op_draw = $urandom_range(OP_ADD_SAMPLE, OP_SPARE_LAST);
                if (op_draw == OP_CLEAR) op_draw = OP_SPARE_FIRST;
                pending_cmds.push_back(make_cmd(OPC_W'(op_draw),
                    $urandom_range(0, 63), draw_duration(), $urandom_range(0, 127)));
                made++;
            end
            else begin
                k = $urandom_range(1, 6);
                for (int i = 0; i < k; i++) begin
                    if ($urandom_range(0, 3) == 0)
                        pending_cmds.push_back(make_cmd(OP_ADD_COUNT, hot[$urandom_range(0, 3)],
                                                        draw_calls(), $urandom_range(0, 127)));
                    else
                        pending_cmds.push_back(make_cmd(OP_ADD_SAMPLE,
                                                        hot[$urandom_range(0, 3)],
                                                        draw_duration(),
                                                        $urandom_range(0, 127)));
                end
                pending_cmds.push_back(make_cmd(OP_END_FRAME, $urandom_range(0, 63),
                                                draw_duration(), $urandom_range(0, 127)));
                made += k + 1;
                k = $urandom_range(0, 2);
                for (int i = 0; i < k; i++) begin
                    pending_cmds.push_back(make_cmd(OP_QUERY, hot[$urandom_range(0, 3)],
                                                    draw_duration(), draw_pct()));
                end
                made += k;
            end
        end
        // closing query: its answer means the block has drained
        pending_cmds.push_back(make_cmd(OP_QUERY, hot[0], '0, draw_pct()));
    endtask

    // wait for the last answer, then let the block settle before a register write
    task automatic drain_block();
        while (pending_cmds.size() != 0 || in_valid || awaited_reports.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_enable(logic v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        shadow_enable = v;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic phase_enable[5];
        int   s;
        error_count    = 0;
        quiet_mode     = 1'b0;
        start_hold     = 1'b0;
        transfer_count = 0;
        cycle_count    = 0;
        shadow_enable  = 1'b0;
        wipe_shadow();
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // disabled after reset: counts and frame ends do nothing, spares ignored
        pending_cmds.push_back(make_cmd(OP_ADD_SAMPLE, 5, 40'd1000, 0));
        pending_cmds.push_back(make_cmd(OP_ADD_COUNT, 5, 40'd7, 0));
        pending_cmds.push_back(make_cmd(OP_END_FRAME, 0, '0, 0));
        pending_cmds.push_back(make_cmd(OP_SPARE_FIRST, 5, AMOUNT_TOP, 127));
        pending_cmds.push_back(make_cmd(OP_SPARE_LAST, 5, AMOUNT_TOP, 127));
        pending_cmds.push_back(make_cmd(OP_QUERY, 5, '0, 50));
        drain_block();
        write_enable(1'b1);

        // field extremes, exact and log buckets, percent corners, call saturation
        pending_cmds.push_back(make_cmd(OP_ADD_SAMPLE, 0, '0, 0));
        pending_cmds.push_back(make_cmd(OP_ADD_SAMPLE, 63, AMOUNT_TOP, 127));
        pending_cmds.push_back(make_cmd(OP_ADD_COUNT, 1, AMOUNT_TOP, 0));
        pending_cmds.push_back(make_cmd(OP_ADD_SAMPLE, 2, 40'd31, 0));
        pending_cmds.push_back(make_cmd(OP_ADD_SAMPLE, 2, 40'd32, 0));
        pending_cmds.push_back(make_cmd(OP_END_FRAME, 0, '0, 0));
        pending_cmds.push_back(make_cmd(OP_ADD_SAMPLE, 2, 40'd5, 0));
        pending_cmds.push_back(make_cmd(OP_ADD_COUNT, 3, '0, 0));
        pending_cmds.push_back(make_cmd(OP_END_FRAME, 0, '0, 0));
        pending_cmds.push_back(make_cmd(OP_QUERY, 63, '0, 100));
        pending_cmds.push_back(make_cmd(OP_QUERY, 2, '0, 0));
        pending_cmds.push_back(make_cmd(OP_QUERY, 2, '0, 127));
        pending_cmds.push_back(make_cmd(OP_QUERY, 2, '0, 1));
        pending_cmds.push_back(make_cmd(OP_QUERY, 1, '0, 50));
        pending_cmds.push_back(make_cmd(OP_QUERY, 0, '0, 50));
        pending_cmds.push_back(make_cmd(OP_QUERY, 9, '0, 50));
        pending_cmds.push_back(make_cmd(OP_CLEAR, 0, '0, 0));
        pending_cmds.push_back(make_cmd(OP_QUERY, 2, '0, 100));
        pending_cmds.push_back(make_cmd(OP_END_FRAME, 0, '0, 0));
        pending_cmds.push_back(make_cmd(OP_QUERY, 63, '0, 100));
        drain_block();

        // frame duration saturation: many full-scale samples into one slot
        s = $urandom_range(0, 63);
        for (int i = 0; i < 260; i++) begin
            pending_cmds.push_back(make_cmd(OP_ADD_SAMPLE, s, AMOUNT_TOP, 0));
        end
        pending_cmds.push_back(make_cmd(OP_END_FRAME, 0, '0, 0));
        pending_cmds.push_back(make_cmd(OP_QUERY, s, '0, 100));
        drain_block();

        phase_enable = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        for (int p = 0; p < 5; p++) begin
            if (shadow_enable != phase_enable[p]) write_enable(phase_enable[p]);
            queue_random_phase(170, p == 1 || p == 3);
            if (p == 0) start_hold = 1'b1;
            drain_block();
        end

        if (error_count == 0) begin
            $display("per_slot_latency_histogram_stats_test passed");
        end
        else begin
            $display("per_slot_latency_histogram_stats_test failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/plhs_pkg.sv
design/plhs_fifo.sv
design/plhs_front.sv
design/plhs_back.sv
design/per_slot_latency_histogram_stats.sv
bench/per_slot_latency_histogram_stats_test.sv
